### rtl/hsd_pkg.sv
// Shared types and constants of the Huffman stream decoder.
package hsd_pkg;

  localparam int NODE_W  = 9;
  localparam int ENTRY_W = 19;
  localparam int HDR_LEN = 9;
  localparam int CNT_LEN = 8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TREE   = 2'd1,
    PH_DATA   = 2'd2,
    PH_HALT   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_T_STK,
    ST_T_TAB,
    ST_D_CHILD,
    ST_RES,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       file_done;
    logic       malformed;
  } hsd_res_t;

  typedef struct packed {
    hsd_res_t res;
    logic     last;
  } hsd_out_t;

endpackage

### rtl/huffman_stream_decoder.sv
// Huffman stream decoder: header parse, preorder tree rebuild and bit-serial tree walk.
// Header bytes and ignored bytes are taken in ST_IDLE alone. Later bytes are shifted one bit at a time:
// a tree bit passes ST_BIT, and also ST_T_STK and ST_T_TAB when a node is linked (stack read, table read);
// a data bit passes ST_BIT, and also ST_D_CHILD on a child read of the node table, plus ST_RES per result.
// A new byte is accepted only in ST_IDLE, once the last one is flushed; output stalls hold the walk.
// Reset is synchronous; node table and stack are not cleared and are rewritten per file.
module huffman_stream_decoder
  import hsd_pkg::*;
#(
  parameter int MAX_NODES   = 511,
  parameter int STACK_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] stream_byte
  input  logic       s_tuser,   // [0] start_of_file
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] symbol
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] file_done, [1] malformed
);

  localparam int TA_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int SD_W = $clog2(STACK_DEPTH + 1);
  localparam int NU_W = NODE_W + 1;

  state_t state, state_next;
  phase_t phase, ph_eff;

  logic [3:0]          hdr, hdr_eff;
  logic [63:0]         rem, rem_eff;
  logic [SD_W-1:0]     sd, sd_a;
  logic [NU_W-1:0]     nu;
  logic [3:0]          lbl;
  logic [7:0]          val, val_new;
  logic [7:0]          bsh;
  logic [2:0]          cnt;
  logic [NODE_W-1:0]   n_reg, top, child;
  logic [ENTRY_W-1:0]  cur_entry, root;
  hsd_res_t            res_q, res_c;
  logic                bit_in, in_acc;

  logic [ENTRY_W-1:0]  tab [MAX_NODES];
  logic [NODE_W-1:0]   stk [STACK_DEPTH];
  logic [ENTRY_W-1:0]  tab_q, tab_wd;
  logic [NODE_W-1:0]   stk_q, stk_wd;
  logic [NODE_W-1:0]   tab_wa, tab_ra;
  logic [SP_W-1:0]     stk_wa, stk_ra;
  logic                tab_we, tab_re, stk_we, stk_re;

  logic step_end, step_res, step_halt, set_leaf, dec_rem;
  logic push_ready, flush_ready, bit_adv;
  hsd_out_t m_out;

  assign bit_in   = bsh[7];
  assign val_new  = {val[6:0], bit_in};
  assign child    = bit_in ? cur_entry[NODE_W-1:0] : cur_entry[2*NODE_W-1:NODE_W];
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign ph_eff   = s_tuser ? PH_HEADER : phase;
  assign hdr_eff  = s_tuser ? 4'd0 : hdr;
  assign rem_eff  = s_tuser ? 64'd0 : rem;
  assign bit_adv  = (state == ST_RES) && push_ready;

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab[tab_wa[TA_W-1:0]] <= tab_wd;
    end
    if (tab_re) begin
      tab_q <= tab[tab_ra[TA_W-1:0]];
    end
    if (stk_we) begin
      stk[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_q <= stk[stk_ra];
    end
  end

  // memory control and per-bit decisions
  always_comb begin
    tab_we    = 1'b0;
    tab_re    = 1'b0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    tab_wa    = '0;
    tab_ra    = '0;
    tab_wd    = '0;
    stk_wa    = '0;
    stk_ra    = '0;
    stk_wd    = n_reg;
    sd_a      = sd;
    step_end  = 1'b0;
    step_res  = 1'b0;
    step_halt = 1'b0;
    set_leaf  = 1'b0;
    dec_rem   = 1'b0;
    res_c     = '{symbol: 8'd0, file_done: 1'b0, malformed: 1'b0};
    unique case (state)
      ST_BIT: begin
        if (phase == PH_TREE) begin
          if (lbl != 4'd0) begin
            step_end = 1'b1;
            if (lbl == 4'd1) begin
              tab_we    = 1'b1;
              tab_wa    = NODE_W'(nu - NU_W'(1));
              tab_wd    = {1'b1, 10'd0, val_new};
              step_halt = (sd == '0) && (rem == 64'd0);
            end
          end else if (nu >= NU_W'(MAX_NODES)) begin
            step_res        = 1'b1;
            step_halt       = 1'b1;
            res_c.malformed = 1'b1;
          end else begin
            tab_we = 1'b1;
            tab_wa = nu[NODE_W-1:0];
            if (nu != '0) begin
              if (sd == '0) begin
                step_res        = 1'b1;
                step_halt       = 1'b1;
                res_c.malformed = 1'b1;
              end else begin
                stk_re = 1'b1;
                stk_ra = SP_W'(sd - SD_W'(1));
              end
            end else begin
              stk_wd = nu[NODE_W-1:0];
              if (bit_in) begin
                set_leaf = 1'b1;
                step_end = 1'b1;
              end else if (sd >= SD_W'(STACK_DEPTH)) begin
                step_res        = 1'b1;
                step_halt       = 1'b1;
                res_c.malformed = 1'b1;
              end else begin
                stk_we   = 1'b1;
                stk_wa   = sd[SP_W-1:0];
                step_end = 1'b1;
              end
            end
          end
        end else begin
          if (cur_entry[ENTRY_W-1]) begin
            step_res        = 1'b1;
            dec_rem         = 1'b1;
            res_c.symbol    = cur_entry[7:0];
            res_c.file_done = (rem == 64'd1);
            step_halt       = (rem == 64'd1);
          end else begin
            tab_re = 1'b1;
            tab_ra = child;
          end
        end
      end
      ST_T_STK: begin
        tab_re = 1'b1;
        tab_ra = stk_q;
      end
      ST_T_TAB: begin
        tab_we = 1'b1;
        tab_wa = top;
        if (tab_q[2*NODE_W-1:NODE_W] == '0) begin
          tab_wd = {tab_q[ENTRY_W-1], n_reg, tab_q[NODE_W-1:0]};
        end else begin
          tab_wd = {tab_q[ENTRY_W-1:NODE_W], n_reg};
          sd_a   = sd - SD_W'(1);
        end
        if (bit_in) begin
          set_leaf = 1'b1;
          step_end = 1'b1;
        end else if (sd_a >= SD_W'(STACK_DEPTH)) begin
          step_res        = 1'b1;
          step_halt       = 1'b1;
          res_c.malformed = 1'b1;
        end else begin
          stk_we   = 1'b1;
          stk_wa   = sd_a[SP_W-1:0];
          step_end = 1'b1;
        end
      end
      ST_D_CHILD: begin
        if (tab_q[ENTRY_W-1]) begin
          step_res        = 1'b1;
          dec_rem         = 1'b1;
          res_c.symbol    = tab_q[7:0];
          res_c.file_done = (rem == 64'd1);
          step_halt       = (rem == 64'd1);
        end else begin
          step_end = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (ph_eff == PH_TREE || ph_eff == PH_DATA)) begin
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        priority if (step_res) begin
          state_next = ST_RES;
        end else if (step_end) begin
          state_next = (cnt == 3'd7 || step_halt) ? ST_FLUSH : ST_BIT;
        end else if (phase == PH_TREE) begin
          state_next = ST_T_STK;
        end else begin
          state_next = ST_D_CHILD;
        end
      end
      ST_T_STK: state_next = ST_T_TAB;
      ST_T_TAB, ST_D_CHILD: begin
        if (step_res) begin
          state_next = ST_RES;
        end else begin
          state_next = (cnt == 3'd7 || step_halt) ? ST_FLUSH : ST_BIT;
        end
      end
      ST_RES: begin
        if (push_ready) begin
          state_next = (cnt == 3'd7 || phase == PH_HALT) ? ST_FLUSH : ST_BIT;
        end
      end
      ST_FLUSH: begin
        if (flush_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_HEADER;
      hdr   <= 4'd0;
      rem   <= 64'd0;
      sd    <= '0;
      nu    <= '0;
      lbl   <= 4'd0;
      val   <= 8'd0;
    end else begin
      state <= state_next;
      if (tab_we && tab_wa == '0) begin
        root <= tab_wd;
      end
      if (step_end || bit_adv) begin
        bsh <= {bsh[6:0], 1'b0};
        cnt <= cnt + 3'd1;
      end
      if (step_res) begin
        res_q <= res_c;
      end
      if (step_halt) begin
        phase <= PH_HALT;
      end
      if (dec_rem) begin
        rem <= rem - 64'd1;
      end
      if (set_leaf) begin
        lbl <= 4'd8;
        val <= 8'd0;
      end
      if (stk_we) begin
        sd <= sd_a + SD_W'(1);
      end else if (state == ST_T_TAB) begin
        sd <= sd_a;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            bsh <= s_tdata;
            cnt <= 3'd0;
            if (s_tuser) begin
              sd  <= '0;
              nu  <= '0;
              lbl <= 4'd0;
              val <= 8'd0;
            end
            if (ph_eff == PH_HEADER) begin
              rem   <= (hdr_eff < 4'(CNT_LEN)) ? {rem_eff[55:0], s_tdata} : rem_eff;
              hdr   <= hdr_eff + 4'd1;
              phase <= (hdr_eff + 4'd1 >= 4'(HDR_LEN)) ? PH_TREE : PH_HEADER;
            end
          end
        end
        ST_BIT: begin
          if (phase == PH_TREE) begin
            if (lbl != 4'd0) begin
              val <= val_new;
              lbl <= lbl - 4'd1;
              if (lbl == 4'd1 && sd == '0) begin
                cur_entry <= (tab_wa == '0) ? tab_wd : root;
                if (rem != 64'd0) begin
                  phase <= PH_DATA;
                end
              end
            end else if (nu < NU_W'(MAX_NODES)) begin
              nu    <= nu + NU_W'(1);
              n_reg <= nu[NODE_W-1:0];
            end
          end
        end
        ST_T_STK: top <= stk_q;
        ST_D_CHILD: begin
          cur_entry <= tab_q[ENTRY_W-1] ? root : tab_q;
        end
        default: begin
        end
      endcase
    end
  end

  hsd_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (state == ST_RES),
    .push_ready  (push_ready),
    .push_res    (res_q),
    .flush_valid (state == ST_FLUSH),
    .flush_ready (flush_ready),
    .m_valid     (m_tvalid),
    .m_ready     (m_tready),
    .m_out       (m_out)
  );

  assign m_tdata = m_out.res.symbol;
  assign m_tlast = m_out.last;
  assign m_tuser = {m_out.res.malformed, m_out.res.file_done};

  a_sd_bound: assert property (@(posedge clk) disable iff (rst)
    sd <= SD_W'(STACK_DEPTH)) else $error("stack depth beyond limit");
  a_nu_bound: assert property (@(posedge clk) disable iff (rst)
    nu <= NU_W'(MAX_NODES)) else $error("node count beyond table");
  a_mal_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tdata == 8'd0 && m_tlast))
    else $error("malformed transaction carries data");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast) else $error("file_done not last");
  a_no_walk_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(tab_re || stk_re || stk_we))
    else $error("memory access while idle");

endmodule

### rtl/hsd_emit.sv
// Result holding stage: keeps one result back until it is known whether it ends the byte.
module hsd_emit
  import hsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  hsd_res_t push_res,
  input  logic     flush_valid,
  output logic     flush_ready,
  output logic     m_valid,
  input  logic     m_ready,
  output hsd_out_t m_out
);

  logic     pend_valid;
  hsd_res_t pend;
  logic     out_free;
  logic     push_acc, load_mid, load_end;

  assign out_free    = !m_valid || m_ready;
  assign push_ready  = !pend_valid || out_free;
  assign flush_ready = !pend_valid || out_free;
  assign push_acc    = push_valid && push_ready;
  assign load_mid    = push_acc && pend_valid;
  assign load_end    = !push_acc && flush_valid && flush_ready && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (load_mid || load_end) begin
        m_out   <= '{res: pend, last: load_end};
        m_valid <= 1'b1;
      end else if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      if (push_acc) begin
        pend       <= push_res;
        pend_valid <= 1'b1;
      end else if (load_end) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

### sim/tb_huffman_stream_decoder.sv
// Self-checking testbench for huffman_stream_decoder with a scoreboard class.
module tb_huffman_stream_decoder
  import hsd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  class hsd_scoreboard;
    phase_t            ph;
    int unsigned       hdr_seen;
    logic [63:0]       remaining;
    logic [18:0]       tbl [512];
    logic [8:0]        stk [256];
    int unsigned       depth;
    int unsigned       used;
    logic [8:0]        cur;
    logic [7:0]        leaf_val;
    int unsigned       leaf_left;
    hsd_out_t          pending [$];
    int                errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_HEADER;
      hdr_seen = 0;
      remaining = '0;
      depth = 0;
      used = 0;
      cur = '0;
      leaf_val = '0;
      leaf_left = 0;
    endfunction

    // one tree bit; 0 means the tree is malformed
    function bit tree_step(bit b);
      logic [8:0]  n;
      logic [8:0]  top;
      logic [18:0] e;
      if (leaf_left > 0) begin
        leaf_val = {leaf_val[6:0], b};
        leaf_left--;
        if (leaf_left == 0) begin
          tbl[used - 1] = {1'b1, 10'd0, leaf_val};
          if (depth == 0) begin
            cur = '0;
            ph = (remaining == 0) ? PH_HALT : PH_DATA;
          end
        end
        return 1;
      end
      if (used >= 511) return 0;
      n = used[8:0];
      used++;
      tbl[n] = '0;
      if (n != 0) begin
        if (depth == 0 || depth > 256) return 0;
        top = stk[depth - 1];
        e = tbl[top];
        if (e[17:9] == 0) tbl[top] = e | {1'b0, n, 9'd0};
        else begin
          tbl[top] = {e[18:9], n};
          depth--;
        end
      end
      if (b) begin
        leaf_left = 8;
        leaf_val = '0;
      end else begin
        if (depth >= 256) return 0;
        stk[depth] = n;
        depth++;
      end
      return 1;
    endfunction

    function void note_byte(logic [7:0] data, bit sof);
      int          cnt;
      bit          b;
      bit          hit;
      logic [7:0]  sym;
      logic [18:0] e;
      logic [8:0]  child;
      hsd_out_t    r;
      cnt = 0;
      if (sof) clear();
      if (ph == PH_HEADER) begin
        if (hdr_seen < CNT_LEN) remaining = {remaining[55:0], data};
        hdr_seen++;
        if (hdr_seen >= HDR_LEN) ph = PH_TREE;
        return;
      end
      for (int i = 7; i >= 0 && ph != PH_HALT; i--) begin
        b = data[i];
        if (ph == PH_TREE) begin
          if (!tree_step(b)) begin
            r = '0;
            r.res.malformed = 1'b1;
            pending = {pending, r};
            cnt++;
            ph = PH_HALT;
          end
        end else begin
          e = tbl[cur];
          hit = 0;
          sym = '0;
          if (e[18]) begin
            hit = 1;
            sym = e[7:0];
            cur = '0;
          end else begin
            child = b ? e[8:0] : e[17:9];
            if (tbl[child][18]) begin
              hit = 1;
              sym = tbl[child][7:0];
              cur = '0;
            end else cur = child;
          end
          if (hit) begin
            remaining--;
            r = '0;
            r.res.symbol = sym;
            r.res.file_done = (remaining == 0);
            pending = {pending, r};
            cnt++;
            if (remaining == 0) ph = PH_HALT;
          end
        end
      end
      if (cnt > 0) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_symbol(logic [7:0] sym, logic last, logic done, logic bad);
      hsd_out_t x;
      if (pending.size() == 0) begin
        $error("unexpected result: symbol %0h", sym);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (sym !== x.res.symbol) begin
        $error("symbol: expected %0h, actual %0h", x.res.symbol, sym);
        errors++;
      end
      if (last !== x.last) begin
        $error("last_in_run: expected %0b, actual %0b", x.last, last);
        errors++;
      end
      if (done !== x.res.file_done) begin
        $error("file_done: expected %0b, actual %0b", x.res.file_done, done);
        errors++;
      end
      if (bad !== x.res.malformed) begin
        $error("malformed: expected %0b, actual %0b", x.res.malformed, bad);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  hsd_scoreboard sb = new();
  bit      bitq [$];
  int      gl [1024];
  int      gr [1024];
  bit      gleaf [1024];
  int      gn;
  int      bytes_sent = 0;
  bit      quiet = 0;
  bit      hold_req = 0;
  bit      holding = 0;
  longint  cycles = 0;

  huffman_stream_decoder dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 100000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !holding && (quiet || $urandom_range(99) >= 7);
  end

  initial begin
    wait (hold_req);
    holding = 1;
    repeat (700) @(posedge clk);
    holding = 0;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready)
      sb.check_symbol(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);

  function automatic void add_bit(bit b);
    bitq = {bitq, b};
  endfunction

  task automatic send_byte(logic [7:0] data, bit sof);
    while (!quiet && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= sof;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(data, sof);
    bytes_sent++;
  endtask

  function automatic int build_tree(int leaves);
    int id;
    int k;
    id = gn++;
    if (leaves == 1) begin
      gleaf[id] = 1;
      add_bit(1'b1);
      for (int i = 0; i < 8; i++) add_bit(1'($urandom_range(1)));
    end else begin
      gleaf[id] = 0;
      add_bit(1'b0);
      k = $urandom_range(1, leaves - 1);
      gl[id] = build_tree(k);
      gr[id] = build_tree(leaves - k);
    end
    return id;
  endfunction

  task automatic send_header(logic [63:0] count);
    for (int i = 7; i >= 0; i--) send_byte(count[i*8 +: 8], i == 7);
    send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic flush_bits();
    logic [7:0] v;
    while (bitq.size() % 8 != 0) add_bit(1'($urandom_range(1)));
    while (bitq.size() > 0) begin
      for (int i = 7; i >= 0; i--) v[i] = bitq.pop_front();
      send_byte(v, 1'b0);
    end
  endtask

  task automatic send_file(logic [63:0] count, int leaves, int nsym, int extra);
    int node;
    int dummy;
    bit b;
    send_header(count);
    bitq.delete();
    gn = 0;
    dummy = build_tree(leaves);
    for (int s = 0; s < nsym; s++) begin
      node = 0;
      if (gleaf[0]) add_bit(1'($urandom_range(1)));
      while (!gleaf[node]) begin
        b = 1'($urandom_range(1));
        add_bit(b);
        node = b ? gr[node] : gl[node];
      end
    end
    flush_bits();
    repeat (extra) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_file(64'd1, 1, 1, 1);
    send_file(64'd3, 1, 3, 0);
    send_file(64'd0, 3, 0, 1);
    // no idling on either side for a while
    quiet = 1;
    send_file(64'd6, 2, 6, 1);
    send_file({$urandom, $urandom}, 5, 8, 2);
    quiet = 0;
    // stack overflow: one long run of internal nodes
    send_header(64'd5);
    repeat (34) send_byte(8'h00, 1'b0);
    hold_req = 1;
    send_file(64'd80, 2, 80, 0);

    while (bytes_sent < 150) begin
      quiet = ($urandom_range(9) == 0);
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 4))
             send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        1: send_file(64'd0, $urandom_range(1, 6), 0, 1);
        2: send_file({$urandom, $urandom}, $urandom_range(2, 8), $urandom_range(1, 10), 0);
        default: begin
          n = $urandom_range(1, 12);
          send_file(64'(n), $urandom_range(1, 16), n, $urandom_range(1));
        end
      endcase
    end
    quiet = 0;
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

### huffman_stream_decoder.f
rtl/hsd_pkg.sv
rtl/hsd_emit.sv
rtl/huffman_stream_decoder.sv
sim/tb_huffman_stream_decoder.sv
